[rtl/chm_pkg.sv]
// ----------------------------------------------------------------------------
// Chained hash map package
// Shared types, codes and hash constants for the chained hash map.
// ----------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

  localparam int TABLE_PRIME = 4093;
  localparam int SLOT_W      = $clog2(TABLE_PRIME);
  localparam int REM_W       = SLOT_W + 1;
  localparam int RECIP_SHIFT = 31 + SLOT_W;
  localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / TABLE_PRIME);
  localparam logic [SLOT_W-1:0] FULL_COUNT = SLOT_W'(TABLE_PRIME - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_PRIME - 1);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic signed [31:0] MISS_VALUE = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        key;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
  } rsp_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  next;
    logic [31:0]        key;
    logic signed [31:0] value;
  } entry_t;

  typedef enum logic [0:0] {
    MUL_RECIP = 1'b0,
    MUL_PRIME = 1'b1
  } mul_sel_t;

  typedef struct packed {
    logic              head_we;
    logic [SLOT_W-1:0] head_waddr;
    logic [SLOT_W-1:0] head_wdata;
    logic [SLOT_W-1:0] head_raddr;
    logic              ent_we;
    logic [SLOT_W-1:0] ent_waddr;
    entry_t            ent_wdata;
    logic [SLOT_W-1:0] ent_raddr;
  } store_ctrl_t;

endpackage

`default_nettype wire

[rtl/chm_hash.sv]
// ----------------------------------------------------------------------------
// Chained hash map bucket hash
// Shared multiplier that reduces a key modulo the prime bucket count in two
// passes: a reciprocal multiply for the quotient, then a multiply by the prime.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_hash (
  input  wire logic                     clk,
  input  wire chm_pkg::mul_sel_t        sel,
  input  wire logic [31:0]              key,
  output logic [chm_pkg::SLOT_W-1:0]    bucket
);

  logic [63:0]               prod;
  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic [31:0]               quot;
  logic [chm_pkg::REM_W-1:0] rem;

  assign quot  = 32'(prod >> chm_pkg::RECIP_SHIFT);
  assign mul_a = (sel == chm_pkg::MUL_RECIP) ? key : quot;
  assign mul_b = (sel == chm_pkg::MUL_RECIP) ? chm_pkg::RECIP : 32'(chm_pkg::TABLE_PRIME);

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // The quotient estimate is at most one low, so one correction suffices.
  assign rem    = chm_pkg::REM_W'(key - prod[31:0]);
  assign bucket = (rem >= chm_pkg::REM_W'(chm_pkg::TABLE_PRIME))
                ? chm_pkg::SLOT_W'(rem - chm_pkg::REM_W'(chm_pkg::TABLE_PRIME))
                : chm_pkg::SLOT_W'(rem);

endmodule

`default_nettype wire

[rtl/chm_store.sv]
// ----------------------------------------------------------------------------
// Chained hash map storage
// Bucket head memory and entry memory, each with one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_store (
  input  wire logic                     clk,
  input  wire chm_pkg::store_ctrl_t     ctrl,
  output logic [chm_pkg::SLOT_W-1:0]    head_rdata,
  output chm_pkg::entry_t               ent_rdata
);

  logic [chm_pkg::SLOT_W-1:0] head_mem [chm_pkg::TABLE_PRIME];
  chm_pkg::entry_t            ent_mem  [chm_pkg::TABLE_PRIME];

  always_ff @(posedge clk) begin
    if (ctrl.head_we) begin
      head_mem[ctrl.head_waddr] <= ctrl.head_wdata;
    end
    head_rdata <= head_mem[ctrl.head_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.ent_we) begin
      ent_mem[ctrl.ent_waddr] <= ctrl.ent_wdata;
    end
    ent_rdata <= ent_mem[ctrl.ent_raddr];
  end

endmodule

`default_nettype wire

[rtl/chained_hash_map_top.sv]
// ----------------------------------------------------------------------------
// Chained hash map
// Hash table with separate chaining: clear, insert with shadowing, and find.
//
//   Channel  Signals                        Word
//   req      req_valid, req_ready, req      op, key, value
//   rsp      rsp_valid, rsp_ready, rsp      status, found_value
//
// Insert, and a find on an empty bucket, pass through the two multiply steps
// and the fix, head and link steps to the reply step; a find on a chain then
// walks it in the compare step, one entry memory read per cycle.
// A rejected insert or an unused op goes from accept straight to the reply step.
// Clear and reset both sweep the bucket head memory, one head per cycle;
// req_ready stays low meanwhile.
// One word is processed at a time; a stalled response holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire chm_pkg::req_word_t req,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output chm_pkg::rsp_word_t      rsp
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_MUL_Q = 9'b000000100,
    S_MUL_R = 9'b000001000,
    S_FIX   = 9'b000010000,
    S_HEAD  = 9'b000100000,
    S_LINK  = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_REPLY = 9'b100000000
  } state_t;

  state_t                     state;
  logic [chm_pkg::SLOT_W-1:0] sweep_idx;
  logic                       sweep_reply;
  logic [1:0]                 op_q;
  logic [31:0]                key_q;
  logic signed [31:0]         value_q;
  logic [chm_pkg::SLOT_W-1:0] bucket;
  logic [chm_pkg::SLOT_W-1:0] walk;
  logic [chm_pkg::SLOT_W-1:0] entry_count;
  logic [1:0]                 res_status;
  logic signed [31:0]         res_value;

  chm_pkg::mul_sel_t          mul_sel;
  logic [chm_pkg::SLOT_W-1:0] hash_bucket;
  chm_pkg::store_ctrl_t       sctrl;
  logic [chm_pkg::SLOT_W-1:0] head_rdata;
  chm_pkg::entry_t            ent_rdata;
  logic [chm_pkg::SLOT_W-1:0] new_slot;
  logic                       key_match;

  assign req_ready = (state == S_IDLE);
  assign new_slot  = entry_count + chm_pkg::SLOT_W'(1);
  assign key_match = (ent_rdata.key == key_q);
  assign mul_sel   = (state == S_MUL_R) ? chm_pkg::MUL_PRIME : chm_pkg::MUL_RECIP;

  chm_hash u_hash (
    .clk    (clk),
    .sel    (mul_sel),
    .key    (key_q),
    .bucket (hash_bucket)
  );

  always_comb begin
    sctrl                 = '0;
    sctrl.head_raddr      = bucket;
    sctrl.ent_raddr       = (state == S_CMP) ? ent_rdata.next : head_rdata;
    sctrl.ent_waddr       = new_slot;
    sctrl.ent_wdata.next  = head_rdata;
    sctrl.ent_wdata.key   = key_q;
    sctrl.ent_wdata.value = value_q;
    if (state == S_SWEEP) begin
      sctrl.head_we    = 1'b1;
      sctrl.head_waddr = sweep_idx;
      sctrl.head_wdata = '0;
    end else if (state == S_LINK && op_q == chm_pkg::OP_INSERT) begin
      sctrl.head_we    = 1'b1;
      sctrl.head_waddr = bucket;
      sctrl.head_wdata = new_slot;
      sctrl.ent_we     = 1'b1;
    end
  end

  chm_store u_store (
    .clk        (clk),
    .ctrl       (sctrl),
    .head_rdata (head_rdata),
    .ent_rdata  (ent_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_idx   <= '0;
      sweep_reply <= 1'b0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_REPLY) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q       <= req.op;
            key_q      <= req.key;
            value_q    <= req.value;
            res_status <= chm_pkg::ST_OK;
            res_value  <= '0;
            if (req.op == chm_pkg::OP_CLEAR) begin
              sweep_idx   <= '0;
              sweep_reply <= 1'b1;
              entry_count <= '0;
              state       <= S_SWEEP;
            end else if (req.op == chm_pkg::OP_INSERT) begin
              if (entry_count >= chm_pkg::FULL_COUNT) begin
                res_status <= chm_pkg::ST_FULL;
                state      <= S_REPLY;
              end else begin
                state <= S_MUL_Q;
              end
            end else if (req.op == chm_pkg::OP_FIND) begin
              state <= S_MUL_Q;
            end else begin
              state <= S_REPLY;
            end
          end
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + chm_pkg::SLOT_W'(1);
          if (sweep_idx == chm_pkg::LAST_SLOT) begin
            state <= sweep_reply ? S_REPLY : S_IDLE;
          end
        end
        S_MUL_Q: begin
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          state <= S_FIX;
        end
        S_FIX: begin
          bucket <= hash_bucket;
          state  <= S_HEAD;
        end
        S_HEAD: begin
          state <= S_LINK;
        end
        S_LINK: begin
          if (op_q == chm_pkg::OP_INSERT) begin
            entry_count <= new_slot;
            state       <= S_REPLY;
          end else if (head_rdata == '0) begin
            res_status <= chm_pkg::ST_MISS;
            res_value  <= chm_pkg::MISS_VALUE;
            state      <= S_REPLY;
          end else begin
            walk  <= head_rdata;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_match) begin
            res_value <= ent_rdata.value;
            state     <= S_REPLY;
          end else if (ent_rdata.next == '0) begin
            res_status <= chm_pkg::ST_MISS;
            res_value  <= chm_pkg::MISS_VALUE;
            state      <= S_REPLY;
          end else begin
            walk <= ent_rdata.next;
          end
        end
        S_REPLY: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.found_value <= res_value;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= chm_pkg::FULL_COUNT)
    else $error("entry count past the last slot");

  a_walk_descends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && !key_match && ent_rdata.next != '0) |-> ent_rdata.next < walk)
    else $error("chain link does not point to an older slot");

  a_rsp_from_reply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_REPLY))
    else $error("response loaded outside the reply step");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPLY && res_status == chm_pkg::ST_FULL) |->
      entry_count == chm_pkg::FULL_COUNT)
    else $error("full status with free slots left");

endmodule

`default_nettype wire

[test/chained_hash_map_checker.sv]
// ----------------------------------------------------------------------------
// Chained hash map checker
// Watches both channels of the chained hash map and keeps a table of its own.
// It works out the answer to every accepted request word and compares each
// accepted response word with the oldest answer due. It hands the mismatch
// count and the number of answers still due to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               req_ready,
  input  wire chm_pkg::req_word_t req,
  input  wire logic               rsp_valid,
  input  wire logic               rsp_ready,
  input  wire chm_pkg::rsp_word_t rsp,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [chm_pkg::SLOT_W-1:0] head_of  [chm_pkg::TABLE_PRIME];
  logic [chm_pkg::SLOT_W-1:0] link_of  [chm_pkg::TABLE_PRIME];
  logic [31:0]                key_of   [chm_pkg::TABLE_PRIME];
  logic signed [31:0]         value_of [chm_pkg::TABLE_PRIME];
  int unsigned                slots_filled;
  chm_pkg::rsp_word_t         answers_due [$];
  int                         mismatches = 0;

  function automatic chm_pkg::rsp_word_t run_map_op(chm_pkg::req_word_t w);
    chm_pkg::rsp_word_t         a;
    logic [chm_pkg::SLOT_W-1:0] b;
    logic [chm_pkg::SLOT_W-1:0] e;
    logic [chm_pkg::SLOT_W-1:0] slot;
    int                         guard;
    a.status      = chm_pkg::ST_OK;
    a.found_value = '0;
    b = chm_pkg::SLOT_W'(w.key % 32'(chm_pkg::TABLE_PRIME));
    case (w.op)
      chm_pkg::OP_CLEAR: begin
        foreach (head_of[i]) head_of[i] = '0;
        slots_filled = 0;
      end
      chm_pkg::OP_INSERT: begin
        if (slots_filled >= chm_pkg::TABLE_PRIME - 1) begin
          a.status = chm_pkg::ST_FULL;
        end else begin
          slots_filled++;
          slot           = chm_pkg::SLOT_W'(slots_filled);
          link_of[slot]  = head_of[b];
          head_of[b]     = slot;
          key_of[slot]   = w.key;
          value_of[slot] = w.value;
        end
      end
      chm_pkg::OP_FIND: begin
        a.status      = chm_pkg::ST_MISS;
        a.found_value = chm_pkg::MISS_VALUE;
        e             = head_of[b];
        guard         = 0;
        while (e != 0 && e < chm_pkg::TABLE_PRIME && guard < chm_pkg::TABLE_PRIME) begin
          if (key_of[e] == w.key) begin
            a.status      = chm_pkg::ST_OK;
            a.found_value = value_of[e];
            break;
          end
          e = link_of[e];
          guard++;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    chm_pkg::rsp_word_t want;
    if (rst) begin
      foreach (head_of[i]) head_of[i] = '0;
      slots_filled = 0;
      answers_due.delete();
    end else begin
      // The response side goes first, so a word can never meet its own answer.
      if (rsp_valid && rsp_ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          $display("%0t: response word with no request pending: status %0d found_value %0d",
                   $time, rsp.status, rsp.found_value);
        end else begin
          want = answers_due.pop_front();
          if (rsp.status != want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp.status);
          end
          if (rsp.found_value != want.found_value) begin
            mismatches++;
            $display("%0t: found_value expected %0d actual %0d",
                     $time, want.found_value, rsp.found_value);
          end
        end
      end
      if (req_valid && req_ready) answers_due.push_back(run_map_op(req));
    end
    errors  = mismatches;
    pending = answers_due.size();
  end

endmodule

`default_nettype wire

[test/chained_hash_map_top_tb.sv]
// ----------------------------------------------------------------------------
// Chained hash map testbench
// Drives clear, insert, find and unused-op words into the chained hash map:
// a directed run over chain collisions, shadowing and clear, then a long
// random run that mixes a small pool of colliding keys with random keys.
// Both sides stall at random, except early in the random run; the checker judges results.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_map_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 5_000_000;
  localparam int          RANDOM_ITEMS = 1700;
  localparam int          KEY_POOL     = 24;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  chm_pkg::req_word_t req       = '0;
  logic               rsp_ready = 1'b0;
  logic               req_ready;
  logic               rsp_valid;
  chm_pkg::rsp_word_t rsp;
  int                 errors;
  int                 pending;
  bit                 stall_en  = 1'b1;
  int                 cycles    = 0;
  logic [31:0]        last_key  = '0;
  logic [31:0]        key_pool [KEY_POOL];
  logic [31:0]        hot_bucket [4];

  chained_hash_map_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  chained_hash_map_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_ready = stall_en ? ($urandom_range(99) >= 32) : 1'b1;
  end

  task automatic put_word(logic [1:0] op, logic [31:0] key, logic signed [31:0] value);
    while (stall_en && $urandom_range(99) < 32) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req.op    = op;
    req.key   = key;
    req.value = value;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid = 1'b0;
    if (op == chm_pkg::OP_INSERT) begin
      last_key = key;
    end
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key(int pool_pct);
    if ($urandom_range(99) < pool_pct) return key_pool[$urandom_range(KEY_POOL - 1)];
    return $urandom();
  endfunction

  initial begin
    int done;
    int sel;
    foreach (hot_bucket[i]) hot_bucket[i] = $urandom_range(chm_pkg::TABLE_PRIME - 1);
    foreach (key_pool[i]) begin
      key_pool[i] = hot_bucket[i % 4] + 32'(chm_pkg::TABLE_PRIME) * $urandom_range(1_049_000);
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Collisions in bucket zero, shadowing, and the value extremes.
    put_word(chm_pkg::OP_FIND,   32'd0,           32'sd0);
    put_word(chm_pkg::OP_INSERT, 32'd0,           32'sh7FFF_FFFF);
    put_word(chm_pkg::OP_INSERT, 32'hFFFF_FFFF,   32'sh8000_0000);
    put_word(chm_pkg::OP_FIND,   32'd0,           32'sd0);
    put_word(chm_pkg::OP_FIND,   32'hFFFF_FFFF,   32'sd0);
    put_word(chm_pkg::OP_INSERT, 32'(chm_pkg::TABLE_PRIME),     -32'sd1);
    put_word(chm_pkg::OP_INSERT, 32'(2 * chm_pkg::TABLE_PRIME), 32'sd1);
    put_word(chm_pkg::OP_FIND,   32'(chm_pkg::TABLE_PRIME),     32'sd0);
    put_word(chm_pkg::OP_FIND,   32'd0,           32'sd0);
    put_word(chm_pkg::OP_FIND,   32'(2 * chm_pkg::TABLE_PRIME), 32'sd0);
    put_word(chm_pkg::OP_FIND,   32'(3 * chm_pkg::TABLE_PRIME), 32'sd0);
    put_word(chm_pkg::OP_INSERT, 32'd0,           32'sd5);
    put_word(chm_pkg::OP_FIND,   32'd0,           32'sd0);
    put_word(OP_UNUSED,          32'd0,           32'sh7FFF_FFFF);
    put_word(chm_pkg::OP_CLEAR,  32'hFFFF_FFFF,   -32'sd1);
    put_word(chm_pkg::OP_FIND,   32'd0,           32'sd0);
    put_word(chm_pkg::OP_FIND,   32'hFFFF_FFFF,   32'sd0);
    put_word(chm_pkg::OP_INSERT, 32'hFFFF_FFFF,   32'sd123);
    put_word(chm_pkg::OP_FIND,   32'hFFFF_FFFF,   32'sd0);

    done     = 0;
    stall_en = 1'b0;
    while (done < RANDOM_ITEMS) begin
      if (done == 400) stall_en = 1'b1;
      if (done == 1000) drain();
      sel = $urandom_range(199);
      if (sel < 3) begin
        put_word(chm_pkg::OP_CLEAR, $urandom(), $urandom());
        done++;
      end else if (sel < 6) begin
        put_word(OP_UNUSED, $urandom(), $urandom());
      end else if (sel < 86) begin
        put_word(chm_pkg::OP_INSERT, pick_key(60), $urandom());
        done++;
      end else begin
        if ($urandom_range(9) == 0) put_word(chm_pkg::OP_FIND, last_key, $urandom());
        else put_word(chm_pkg::OP_FIND, pick_key(65), $urandom());
        done++;
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/chm_pkg.sv
rtl/chm_hash.sv
rtl/chm_store.sv
rtl/chained_hash_map_top.sv
test/chained_hash_map_checker.sv
test/chained_hash_map_top_tb.sv
